// ===== sv/adcd_pkg.sv =====
package adcd_pkg;

    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);

    localparam logic [HIST_AW:0] HIST_FULL = (HIST_AW + 1)'(HIST_DEPTH);

    typedef logic [7:0] byte_t;

    // Token phase while waiting for compressed bytes.
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_LITERAL  = 3'd1,
        PH_SHORT_LO = 3'd2,
        PH_LONG_HI  = 3'd3,
        PH_LONG_LO  = 3'd4
    } phase_t;

endpackage

// ===== sv/adc_decompressor_core.sv =====
// ADC block decompressor.
// Input channel: in_valid/in_ready carry one compressed byte per item, with
// block_end marking the last byte of a block. Output channel: out_valid/out_ready
// carry up to four decompressed bytes per item, byte_count of them valid, and
// run_last set on the final item caused by one input byte.
// Header, offset and literal bytes are accepted directly in the idle state; a literal's
// result appears in the output register on the cycle after acceptance.
// A copy moves each byte through S_CP_RD and S_CP_DATA: every copied byte needs one history read
// and one history write on the single 64K x 8 RAM, since a copy may read the
// byte it has just written. in_ready is low during the whole copy.
// The output register is one item deep. When the receiver stalls, the copy
// sequencer holds on a full word or on the copy's last byte and in_ready stays low until the output
// register is free again.
// Reset clears the token state, write pointer and produced-byte count; the history RAM
// is not cleared, since bytes before the start of a block read as zero anyway.
// After block_end the token state and history bookkeeping return to zero once
// the byte's results have been generated.
module adc_decompressor_core
    import adcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       block_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte_0,
    output logic [7:0] out_byte_1,
    output logic [7:0] out_byte_2,
    output logic [7:0] out_byte_3,
    output logic [2:0] byte_count,
    output logic       run_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CP_RD,
        S_CP_DATA
    } state_t;

    state_t              state_reg;
    phase_t              phase_reg;
    logic [7:0]          lit_left_reg;
    logic [6:0]          copy_len_reg;
    logic [6:0]          remain_reg;
    logic [7:0]          off_hi_reg;
    logic [HIST_AW:0]    dist_reg;
    logic [HIST_AW-1:0]  wp_reg;
    logic [HIST_AW:0]    produced_reg;
    logic                end_pend_reg;
    logic [LANE_W-1:0]   cnt_reg;
    byte_t               pack_reg [LANES];
    byte_t               out_reg [LANES];
    logic [2:0]          count_reg;
    logic                last_reg;
    logic                out_valid_reg;

    logic                slot_free;
    logic                accept;
    logic                flush;
    logic                stall;
    byte_t               copy_byte;
    byte_t               pack_word [LANES];
    logic [HIST_AW:0]    produced_inc;
    logic [HIST_AW:0]    short_dist;
    logic [HIST_AW:0]    long_dist;

    logic                ram_we;
    logic [HIST_AW-1:0]  ram_waddr;
    byte_t               ram_wdata;
    logic [HIST_AW-1:0]  ram_raddr;
    byte_t               ram_rdata;

    adcd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    // Bytes further back than the block has produced read as zero.
    assign copy_byte = (dist_reg <= produced_reg) ? ram_rdata : 8'd0;
    assign flush     = (cnt_reg == LANE_W'(LANES - 1)) || (remain_reg == 7'd1);
    assign stall     = flush && !slot_free;

    assign produced_inc = (produced_reg == HIST_FULL) ? produced_reg
                                                      : produced_reg + 1'b1;
    assign short_dist   = (HIST_AW + 1)'({off_hi_reg[1:0], data_byte}) + 1'b1;
    assign long_dist    = (HIST_AW + 1)'({off_hi_reg, data_byte}) + 1'b1;

    assign ram_raddr = wp_reg - dist_reg[HIST_AW-1:0];
    assign ram_waddr = wp_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            pack_word[i] = pack_reg[i];
        end
        pack_word[cnt_reg] = copy_byte;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = data_byte;
        if (accept && (phase_reg == PH_LITERAL))
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == S_CP_DATA) && !stall)
        begin
            ram_we    = 1'b1;
            ram_wdata = copy_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HEADER;
            lit_left_reg  <= '0;
            copy_len_reg  <= '0;
            remain_reg    <= '0;
            off_hi_reg    <= '0;
            dist_reg      <= '0;
            wp_reg        <= '0;
            produced_reg  <= '0;
            end_pend_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (phase_reg)
                            PH_LITERAL:
                            begin
                                wp_reg       <= wp_reg + 1'b1;
                                produced_reg <= produced_inc;
                                out_reg[0]   <= data_byte;
                                for (int i = 1; i < LANES; i++)
                                begin
                                    out_reg[i] <= 8'd0;
                                end
                                count_reg     <= 3'd1;
                                last_reg      <= 1'b1;
                                out_valid_reg <= 1'b1;
                                lit_left_reg  <= lit_left_reg - 1'b1;
                                if (lit_left_reg == 8'd1)
                                begin
                                    phase_reg <= PH_HEADER;
                                end
                            end
                            PH_SHORT_LO, PH_LONG_LO:
                            begin
                                dist_reg     <= (phase_reg == PH_SHORT_LO) ? short_dist
                                                                           : long_dist;
                                remain_reg   <= copy_len_reg;
                                end_pend_reg <= block_end;
                                cnt_reg      <= '0;
                                for (int i = 0; i < LANES; i++)
                                begin
                                    pack_reg[i] <= 8'd0;
                                end
                                phase_reg <= PH_HEADER;
                                state_reg <= S_CP_RD;
                            end
                            PH_LONG_HI:
                            begin
                                off_hi_reg <= data_byte;
                                phase_reg  <= PH_LONG_LO;
                            end
                            default:
                            begin
                                if (data_byte[7])
                                begin
                                    lit_left_reg <= {1'b0, data_byte[6:0]} + 8'd1;
                                    phase_reg    <= PH_LITERAL;
                                end
                                else if (data_byte[6])
                                begin
                                    copy_len_reg <= {1'b0, data_byte[5:0]} + 7'd4;
                                    phase_reg    <= PH_LONG_HI;
                                end
                                else
                                begin
                                    copy_len_reg <= {3'd0, data_byte[5:2]} + 7'd3;
                                    off_hi_reg   <= {6'd0, data_byte[1:0]};
                                    phase_reg    <= PH_SHORT_LO;
                                end
                            end
                        endcase

                        // A copy clears the block state when it finishes instead.
                        if (block_end && (phase_reg != PH_SHORT_LO)
                            && (phase_reg != PH_LONG_LO))
                        begin
                            phase_reg    <= PH_HEADER;
                            lit_left_reg <= '0;
                            copy_len_reg <= '0;
                            off_hi_reg   <= '0;
                            wp_reg       <= '0;
                            produced_reg <= '0;
                        end
                    end
                end

                S_CP_RD:
                begin
                    state_reg <= S_CP_DATA;
                end

                S_CP_DATA:
                begin
                    if (!stall)
                    begin
                        wp_reg       <= wp_reg + 1'b1;
                        produced_reg <= produced_inc;
                        remain_reg   <= remain_reg - 1'b1;
                        if (flush)
                        begin
                            for (int i = 0; i < LANES; i++)
                            begin
                                out_reg[i]  <= pack_word[i];
                                pack_reg[i] <= 8'd0;
                            end
                            count_reg     <= 3'({1'b0, cnt_reg}) + 3'd1;
                            last_reg      <= (remain_reg == 7'd1);
                            out_valid_reg <= 1'b1;
                            cnt_reg       <= '0;
                        end
                        else
                        begin
                            for (int i = 0; i < LANES; i++)
                            begin
                                pack_reg[i] <= pack_word[i];
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                        end

                        if (remain_reg == 7'd1)
                        begin
                            state_reg <= S_IDLE;
                            if (end_pend_reg)
                            begin
                                phase_reg    <= PH_HEADER;
                                lit_left_reg <= '0;
                                copy_len_reg <= '0;
                                off_hi_reg   <= '0;
                                wp_reg       <= '0;
                                produced_reg <= '0;
                            end
                        end
                        else
                        begin
                            state_reg <= S_CP_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte_0 = out_reg[0];
    assign out_byte_1 = out_reg[1];
    assign out_byte_2 = out_reg[2];
    assign out_byte_3 = out_reg[3];
    assign byte_count = count_reg;
    assign run_last   = last_reg;

endmodule

// ===== sv/adcd_ram.sv =====
module adcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import adcd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 250;
    localparam int MAX_GAP      = 13;
    localparam int TAIL_CYCLES  = 150;
    localparam int REPORT_LIMIT = 10;

    // Header byte classes, taken from bits 7..6 when bit 7 is clear.
    localparam bit [1:0] HDR_SHORT = 2'b00;
    localparam bit [1:0] HDR_LONG  = 2'b01;

    typedef struct packed {
        logic [3:0][7:0] lanes;
        logic [2:0]      count;
        logic            run_end;
    } out_word_t;

    class adc_scoreboard;
        phase_t      phase;
        bit [7:0]    lits_left;
        bit [6:0]    copy_len;
        bit [7:0]    off_hi;
        byte_t       history_mem [HIST_DEPTH];
        bit [15:0]   wr_ptr;
        int unsigned made;
        byte_t       run_q [$];
        out_word_t   want_q [$];
        int          errors;

        function new();
            clear_block();
            errors = 0;
        endfunction

        function void clear_block();
            phase     = PH_HEADER;
            lits_left = '0;
            copy_len  = '0;
            off_hi    = '0;
            wr_ptr    = '0;
            made      = 0;
        endfunction

        function void put_byte(byte_t v);
            history_mem[wr_ptr] = v;
            wr_ptr = wr_ptr + 16'd1;
            if (made < HIST_DEPTH)
                made++;
            run_q = {run_q, v};
        endfunction

        // Bytes are copied one at a time so an overlapping copy repeats
        // the bytes it has just written.
        function void copy_back(bit [15:0] offset);
            int unsigned distance;
            byte_t       v;
            distance = offset + 1;
            for (int k = 0; k < copy_len; k++)
            begin
                v = '0;
                if (distance <= made)
                    v = history_mem[wr_ptr - 16'(distance)];
                put_byte(v);
            end
        endfunction

        function void note_byte(byte_t b, logic blk_end);
            out_word_t w;
            int        take;
            case (phase)
                PH_LITERAL:
                begin
                    put_byte(b);
                    lits_left = lits_left - 8'd1;
                    if (lits_left == 0)
                        phase = PH_HEADER;
                end
                PH_SHORT_LO:
                begin
                    copy_back({6'd0, off_hi[1:0], b});
                    phase = PH_HEADER;
                end
                PH_LONG_HI:
                begin
                    off_hi = b;
                    phase  = PH_LONG_LO;
                end
                PH_LONG_LO:
                begin
                    copy_back({off_hi, b});
                    phase = PH_HEADER;
                end
                default:
                begin
                    if (b[7])
                    begin
                        lits_left = {1'b0, b[6:0]} + 8'd1;
                        phase     = PH_LITERAL;
                    end
                    else if (b[7:6] == HDR_LONG)
                    begin
                        copy_len = {1'b0, b[5:0]} + 7'd4;
                        phase    = PH_LONG_HI;
                    end
                    else
                    begin
                        copy_len = {3'd0, b[5:2]} + 7'd3;
                        off_hi   = {6'd0, b[1:0]};
                        phase    = PH_SHORT_LO;
                    end
                end
            endcase
            if (blk_end)
                clear_block();
            while (run_q.size() > 0)
            begin
                w    = '0;
                take = (run_q.size() > LANES) ? LANES : run_q.size();
                for (int j = 0; j < take; j++)
                    w.lanes[j] = run_q.pop_front();
                w.count   = 3'(take);
                w.run_end = (run_q.size() == 0);
                want_q = {want_q, w};
            end
        endfunction

        function void report(string what, out_word_t want, out_word_t got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%s: expected %h %h %h %h count %0d last %0b, got %h %h %h %h count %0d last %0b",
                         what, want.lanes[0], want.lanes[1], want.lanes[2], want.lanes[3],
                         want.count, want.run_end, got.lanes[0], got.lanes[1],
                         got.lanes[2], got.lanes[3], got.count, got.run_end);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            bit        bad;
            if (want_q.size() == 0)
            begin
                report("Unexpected result", '0, got);
            end
            else
            begin
                want = want_q.pop_front();
                bad  = (want.count !== got.count) || (want.run_end !== got.run_end);
                for (int j = 0; j < LANES; j++)
                    if (want.lanes[j] !== got.lanes[j])
                        bad = 1'b1;
                if (bad)
                    report("Mismatch", want, got);
            end
        endfunction

        function int unsigned outstanding();
            return want_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       block_end;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte_0;
    logic [7:0] out_byte_1;
    logic [7:0] out_byte_2;
    logic [7:0] out_byte_3;
    logic [2:0] byte_count;
    logic       run_last;

    adc_scoreboard sb;
    bit            no_idle;
    int            items_sent;
    int            idle_cycles;
    byte_t         blk_q [$];
    bit            blk_end_q [$];

    adc_decompressor_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .block_end  (block_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte_0 (out_byte_0),
        .out_byte_1 (out_byte_1),
        .out_byte_2 (out_byte_2),
        .out_byte_3 (out_byte_3),
        .byte_count (byte_count),
        .run_last   (run_last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Valid stays high between back-to-back items; it is only lowered
    // when a gap is drawn, so it never gets two updates in one step.
    task automatic send_byte(input byte_t b, input logic e);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        block_end <= e;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(b, e);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    task automatic send_queued();
        for (int i = 0; i < blk_q.size(); i++)
            send_byte(blk_q[i], blk_end_q[i]);
        blk_q.delete();
        blk_end_q.delete();
    endtask

    task automatic queue_byte(input byte_t b);
        blk_q     = {blk_q, b};
        blk_end_q = {blk_end_q, 1'b0};
    endtask

    // Copy offsets mostly land inside what the block has produced so far,
    // so that copies repeat real data rather than the zero fill.
    function automatic int unsigned pick_offset(int unsigned made, int unsigned span);
        if (made > 0 && $urandom_range(0, 3) != 0)
            return $urandom_range(0, ((made < span) ? made : span) - 1);
        return $urandom_range(0, span - 1);
    endfunction

    task automatic build_block();
        int unsigned gen_made;
        int          lit_len;
        bit [5:0]    len;
        bit [15:0]   off;
        gen_made = 0;
        if ($urandom_range(0, 7) == 0)
        begin
            // Noise: raw bytes, possibly with stray block ends inside.
            repeat ($urandom_range(1, 12))
            begin
                blk_q     = {blk_q, byte_t'($urandom_range(0, 255))};
                blk_end_q = {blk_end_q, ($urandom_range(0, 9) == 0)};
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        lit_len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128)
                                                               : $urandom_range(1, 8);
                        queue_byte({1'b1, 7'(lit_len - 1)});
                        repeat (lit_len)
                            queue_byte(byte_t'($urandom_range(0, 255)));
                        gen_made += lit_len;
                    end
                    1:
                    begin
                        len = 6'($urandom_range(0, 15));
                        off = 16'(pick_offset(gen_made, 1024));
                        queue_byte({HDR_SHORT, len[3:0], off[9:8]});
                        queue_byte(off[7:0]);
                        gen_made += len + 3;
                    end
                    default:
                    begin
                        len = 6'($urandom_range(0, 63));
                        off = 16'(pick_offset(gen_made, HIST_DEPTH));
                        queue_byte({HDR_LONG, len});
                        queue_byte(off[15:8]);
                        queue_byte(off[7:0]);
                        gen_made += len + 4;
                    end
                endcase
            end
            // Now and then the block ends inside a token that never completes.
            if ($urandom_range(0, 4) == 0)
                queue_byte(byte_t'($urandom_range(0, 255)));
        end
        blk_end_q[blk_end_q.size() - 1] = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int        gap;
        out_word_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.lanes[0] = out_byte_0;
            got.lanes[1] = out_byte_1;
            got.lanes[2] = out_byte_2;
            got.lanes[3] = out_byte_3;
            got.count    = byte_count;
            got.run_end  = run_last;
            sb.check_word(got);
        end
    end

    initial
    begin
        int random_goal;
        int blocks;
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = '0;
        block_end   = 1'b0;
        out_ready   = 1'b0;
        no_idle     = 1'b0;
        items_sent  = 0;
        idle_cycles = 0;
        blocks      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Three literals, then a short copy reaching exactly to the block start.
        send_byte(8'h82, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        // Longest short copy, reaching far before the block start: zeros.
        send_byte(8'h3F, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Longest long copy at distance two, so it overlaps itself.
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        // Shortest long copy with the largest offset.
        send_byte(8'h40, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Literal run cut short by the block end.
        send_byte(8'h81, 1'b0);
        send_byte(8'h11, 1'b1);
        // Block end on a bare header and on a long copy's first offset byte.
        send_byte(8'h40, 1'b1);
        send_byte(8'h45, 1'b0);
        send_byte(8'h00, 1'b1);
        // Block end on the byte that completes a copy.
        send_byte(8'h1C, 1'b0);
        send_byte(8'h05, 1'b1);
        wait_drained();

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (blocks == 3)
                wait_drained();
            build_block();
            send_queued();
            blocks++;
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/adcd_pkg.sv
sv/adcd_ram.sv
sv/adc_decompressor_core.sv
tb/testbench.sv
